[rtl/bsas_pkg.sv]
// bsas_pkg: shared types, constants and digit helpers for the bcd sign-magnitude adder
// no dependencies
package bsas_pkg;

  localparam int MAX_DIGITS = 16;
  localparam int NIB_W      = 4;
  localparam int MAG_W      = MAX_DIGITS * NIB_W;

  localparam logic [3:0] DEC_MAX  = 4'd9;
  localparam logic [4:0] DEC_BASE = 5'd10;

  typedef logic [NIB_W-1:0] digit_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_t;

  typedef struct packed {
    logic op;
    logic a_neg;
    mag_t a_bcd;
    logic b_neg;
    mag_t b_bcd;
  } req_t;

  typedef struct packed {
    logic sum_neg;
    mag_t sum_bcd;
    logic overflow;
  } res_t;

  // non-decimal nibbles clamp to nine
  function automatic digit_t sat_digit(digit_t d);
    return (d > DEC_MAX) ? DEC_MAX : d;
  endfunction

endpackage

[rtl/bsas_if.sv]
// bsas_req_if / bsas_res_if: valid-ready channels for requests and results
// depends on bsas_pkg
interface bsas_req_if import bsas_pkg::*;;
  logic valid;
  logic ready;
  logic op;
  logic a_neg;
  mag_t a_bcd;
  logic b_neg;
  mag_t b_bcd;

  modport source (output valid, op, a_neg, a_bcd, b_neg, b_bcd, input ready);
  modport sink   (input valid, op, a_neg, a_bcd, b_neg, b_bcd, output ready);
endinterface

interface bsas_res_if import bsas_pkg::*;;
  logic valid;
  logic ready;
  logic sum_neg;
  mag_t sum_bcd;
  logic overflow;

  modport source (output valid, sum_neg, sum_bcd, overflow, input ready);
  modport sink   (input valid, sum_neg, sum_bcd, overflow, output ready);
endinterface

[rtl/bsas_mag_unit.sv]
// bsas_mag_unit: magnitude compare, decimal add / subtract and sign select
// depends on bsas_pkg
module bsas_mag_unit import bsas_pkg::*; #(
  parameter int DIGITS = 16
) (
  input  req_t q,
  output res_t r
);

  digit_t                xd [MAX_DIGITS];
  digit_t                yd [MAX_DIGITS];
  digit_t                bd [MAX_DIGITS];
  digit_t                sd [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] gen;
  logic [MAX_DIGITS-1:0] prop;
  logic [MAX_DIGITS:0]   c;
  logic                  b_eff_neg;
  logic                  same;
  logic                  a_gt;
  logic                  ovf;
  logic                  neg;
  mag_t                  mag;

  always_comb begin
    logic [4:0] t;
    b_eff_neg = q.b_neg ^ (op_t'(q.op) == OP_SUB);
    same      = (q.a_neg == b_eff_neg);

    // digits above the configured count read as zero
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (i < DIGITS) begin
        xd[i] = sat_digit(q.a_bcd[i*NIB_W +: NIB_W]);
        yd[i] = sat_digit(q.b_bcd[i*NIB_W +: NIB_W]);
      end else begin
        xd[i] = '0;
        yd[i] = '0;
      end
    end

    // higher digits override lower ones
    a_gt = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (xd[i] > yd[i]) begin
        a_gt = 1'b1;
      end else if (xd[i] < yd[i]) begin
        a_gt = 1'b0;
      end
    end

    for (int i = 0; i < MAX_DIGITS; i++) begin
      bd[i] = a_gt ? xd[i] : yd[i];
      sd[i] = a_gt ? yd[i] : xd[i];
      if (same) begin
        t       = {1'b0, xd[i]} + {1'b0, yd[i]};
        gen[i]  = (t >= DEC_BASE);
        prop[i] = (t == {1'b0, DEC_MAX});
      end else begin
        t       = '0;
        gen[i]  = (bd[i] < sd[i]);
        prop[i] = (bd[i] == sd[i]);
      end
    end

    c[0] = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      c[i+1] = gen[i] | (prop[i] & c[i]);
    end

    mag = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (same) begin
        t = {1'b0, xd[i]} + {1'b0, yd[i]} + {4'd0, c[i]};
        if (t >= DEC_BASE) begin
          t = t - DEC_BASE;
        end
      end else begin
        t = {1'b0, bd[i]} - {1'b0, sd[i]} - {4'd0, c[i]};
        if (t[4]) begin
          t = t + DEC_BASE;
        end
      end
      if (i < DIGITS) begin
        mag[i*NIB_W +: NIB_W] = t[NIB_W-1:0];
      end
    end

    ovf = same & c[DIGITS];
    neg = same ? q.a_neg : (a_gt ? q.a_neg : b_eff_neg);
    if (ovf) begin
      mag = '0;
    end
    if (ovf || (mag == '0)) begin
      neg = 1'b0;
    end

    r.sum_neg  = neg;
    r.sum_bcd  = mag;
    r.overflow = ovf;
  end

endmodule

[rtl/bcd_sign_magnitude_add_sub.sv]
// bcd_sign_magnitude_add_sub: signed packed-bcd adder / subtractor, top level
// an accepted request is held in the input register; its result is registered in the output register once that is free
// throughput: one request per cycle while results are taken; the decimal carry chain sits between the two registers
// reset: synchronous active-high rst clears both valid flags; payload registers are not reset
// depends on bsas_pkg, bsas_if, bsas_mag_unit
module bcd_sign_magnitude_add_sub import bsas_pkg::*; #(
  parameter int DIGITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  bsas_req_if.sink          req,
  bsas_res_if.source        res
);

  logic s1_valid;
  req_t s1_req;
  logic s2_valid;
  res_t s2_res;
  logic s1_ready;
  logic s2_ready;
  res_t calc;

  assign s2_ready  = !s2_valid || res.ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign req.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && req.valid) begin
      s1_req.op    <= req.op;
      s1_req.a_neg <= req.a_neg;
      s1_req.a_bcd <= req.a_bcd;
      s1_req.b_neg <= req.b_neg;
      s1_req.b_bcd <= req.b_bcd;
    end
  end

  bsas_mag_unit #(
    .DIGITS (DIGITS)
  ) u_mag (
    .q (s1_req),
    .r (calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_res <= calc;
    end
  end

  assign res.valid    = s2_valid;
  assign res.sum_neg  = s2_res.sum_neg;
  assign res.sum_bcd  = s2_res.sum_bcd;
  assign res.overflow = s2_res.overflow;

  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> s1_valid)
    else $error("accepted request not held in input register");

  a_stage_moves : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> s2_valid)
    else $error("input register drained without a result");

  a_ovf_zero : assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_res.overflow |-> (s2_res.sum_bcd == '0) && !s2_res.sum_neg)
    else $error("overflow result not cleared");

  a_zero_pos : assert property (@(posedge clk) disable iff (rst)
    s2_valid && (s2_res.sum_bcd == '0) |-> !s2_res.sum_neg)
    else $error("negative zero result");

endmodule

[sim/bcd_sign_magnitude_add_sub_tb.sv]
`timescale 1ns / 1ps
// bcd_sign_magnitude_add_sub_tb: drives signed packed-bcd add/sub requests over valid-ready
// and checks each result against a typed or predicted expectation, with random idle and stall
// depends on bsas_pkg, bsas_if and the bcd_sign_magnitude_add_sub rtl
module bcd_sign_magnitude_add_sub_tb;
  import bsas_pkg::*;

  localparam int NDIG        = 16;
  localparam int RAND_PER_PH = 250;
  localparam int CYCLE_LIMIT = 200000;
  localparam mag_t ALL_NINES = 64'h9999_9999_9999_9999;

  typedef struct {
    req_t r;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  bsas_req_if req_ch ();
  bsas_res_if res_ch ();

  bcd_sign_magnitude_add_sub #(.DIGITS(NDIG)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  res_t pending_sums[$];
  int   sum_errors = 0;
  int   n_sent;
  int   n_checked = 0;
  int   n_ovf = 0;
  int   n_neg = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_cnt = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int dec_digit(input mag_t v, input int i);
    logic [3:0] d;
    d = v[4*i +: 4];
    return (d > 4'd9) ? 9 : int'(d);
  endfunction

  // sign-magnitude decimal add or subtract, zero always positive
  function automatic res_t predict_sum(input req_t r);
    res_t  o;
    logic  b_eff;
    logic  do_sub;
    logic  a_gt;
    logic  decided;
    mag_t  big;
    mag_t  lil;
    int    s;
    int    carry;
    b_eff   = r.b_neg ^ (r.op == OP_SUB);
    a_gt    = 1'b0;
    decided = 1'b0;
    for (int i = NDIG - 1; i >= 0; i--) begin
      if (!decided && dec_digit(r.a_bcd, i) != dec_digit(r.b_bcd, i)) begin
        a_gt    = dec_digit(r.a_bcd, i) > dec_digit(r.b_bcd, i);
        decided = 1'b1;
      end
    end
    do_sub = (r.a_neg != b_eff);
    if (!do_sub || a_gt) begin
      big       = r.a_bcd;
      lil       = r.b_bcd;
      o.sum_neg = r.a_neg;
    end else begin
      big       = r.b_bcd;
      lil       = r.a_bcd;
      o.sum_neg = b_eff;
    end
    o.sum_bcd = '0;
    carry     = 0;
    for (int i = 0; i < NDIG; i++) begin
      if (do_sub) begin
        s     = dec_digit(big, i) - dec_digit(lil, i) - carry;
        carry = (s < 0) ? 1 : 0;
        if (carry != 0) s += 10;
      end else begin
        s     = dec_digit(big, i) + dec_digit(lil, i) + carry;
        carry = (s >= 10) ? 1 : 0;
        if (carry != 0) s -= 10;
      end
      o.sum_bcd[4*i +: 4] = 4'(s);
    end
    o.overflow = !do_sub && (carry != 0);
    if (o.overflow) begin
      o.sum_bcd = '0;
      o.sum_neg = 1'b0;
    end
    if (o.sum_bcd == '0) o.sum_neg = 1'b0;
    return o;
  endfunction

  function automatic mag_t rand_mag();
    mag_t m;
    int   ndig;
    m    = '0;
    ndig = $urandom_range(1, NDIG);
    case ($urandom_range(0, 9))
      0: m = {$urandom, $urandom};
      1: begin
        for (int i = 0; i < ndig; i++) m[4*i +: 4] = 4'd9;
      end
      default: begin
        for (int i = 0; i < ndig; i++) m[4*i +: 4] = 4'($urandom_range(0, 9));
      end
    endcase
    return m;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   pick;
    r.op    = $urandom_range(0, 1) ? OP_SUB : OP_ADD;
    r.a_neg = 1'($urandom_range(0, 1));
    r.b_neg = 1'($urandom_range(0, 1));
    r.a_bcd = rand_mag();
    pick    = $urandom_range(0, 19);
    if (pick < 2) begin
      r.b_bcd = r.a_bcd;
    end else if (pick < 4) begin
      r.b_bcd = r.a_bcd;
      r.b_bcd[4*$urandom_range(0, NDIG-1) +: 4] = 4'($urandom_range(0, 9));
    end else begin
      r.b_bcd = rand_mag();
    end
    return r;
  endfunction

  task automatic send_req(input req_t r, input res_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= r.op;
    req_ch.a_neg <= r.a_neg;
    req_ch.a_bcd <= r.a_bcd;
    req_ch.b_neg <= r.b_neg;
    req_ch.b_bcd <= r.b_bcd;
    do @(posedge clk); while (!req_ch.ready);
    pending_sums.push_back(want);
    n_sent++;
  endtask

  // result side stall
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_sums.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t unexpected result: neg %0b bcd %h ovf %0b", $time,
                 res_ch.sum_neg, res_ch.sum_bcd, res_ch.overflow);
        sum_errors++;
      end else begin
        want = pending_sums.pop_front();
        n_checked++;
        if (want.overflow) n_ovf++;
        if (want.sum_neg) n_neg++;
        if (res_ch.sum_neg !== want.sum_neg) begin
          $display("%0t sum_neg: expected %0b actual %0b", $time, want.sum_neg,
                   res_ch.sum_neg);
          sum_errors++;
        end
        if (res_ch.sum_bcd !== want.sum_bcd) begin
          $display("%0t sum_bcd: expected %h actual %h", $time, want.sum_bcd,
                   res_ch.sum_bcd);
          sum_errors++;
        end
        if (res_ch.overflow !== want.overflow) begin
          $display("%0t overflow: expected %0b actual %0b", $time, want.overflow,
                   res_ch.overflow);
          sum_errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t dir_rows[];
    req_t      r;
    int        idle_tab[4];
    int        stall_tab[4];
    idle_tab  = '{0, 74, 0, 19};
    stall_tab = '{0, 0, 74, 19};
    dir_rows = '{
      '{'{OP_ADD, 1'b0, 64'h0, 1'b0, 64'h0}, 1'b1, '{1'b0, 64'h0, 1'b0}},
      // negative zero in, positive zero out
      '{'{OP_ADD, 1'b1, 64'h0, 1'b1, 64'h0}, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_SUB, 1'b1, 64'h0, 1'b0, 64'h0}, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_ADD, 1'b0, ALL_NINES, 1'b0, 64'h1}, 1'b1, '{1'b0, 64'h0, 1'b1}},
      '{'{OP_ADD, 1'b0, ALL_NINES, 1'b0, ALL_NINES}, 1'b1, '{1'b0, 64'h0, 1'b1}},
      '{'{OP_SUB, 1'b1, ALL_NINES, 1'b0, ALL_NINES}, 1'b1, '{1'b0, 64'h0, 1'b1}},
      '{'{OP_SUB, 1'b0, ALL_NINES, 1'b0, ALL_NINES}, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_ADD, 1'b1, 64'h123, 1'b0, 64'h123}, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_ADD, 1'b0, ALL_NINES, 1'b0, 64'h0}, 1'b1, '{1'b0, ALL_NINES, 1'b0}},
      '{'{OP_SUB, 1'b0, 64'h0, 1'b0, ALL_NINES}, 1'b1, '{1'b1, ALL_NINES, 1'b0}},
      '{'{OP_ADD, 1'b0, 64'h5000_0000_0000_0000, 1'b0, 64'h5000_0000_0000_0000}, 1'b1,
        '{1'b0, 64'h0, 1'b1}},
      '{'{OP_ADD, 1'b0, 64'h4999_9999_9999_9999, 1'b0, 64'h5000_0000_0000_0000}, 1'b1,
        '{1'b0, ALL_NINES, 1'b0}},
      '{'{OP_SUB, 1'b0, 64'h1, 1'b0, 64'h2}, 1'b0, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_SUB, 1'b0, 64'h2, 1'b0, 64'h1}, 1'b0, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_SUB, 1'b1, 64'h5, 1'b1, 64'h3}, 1'b0, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_ADD, 1'b1, 64'h3, 1'b0, 64'h8}, 1'b0, '{1'b0, 64'h0, 1'b0}},
      // non-decimal nibbles
      '{'{OP_ADD, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0}, 1'b0, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_SUB, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ALL_NINES}, 1'b0,
        '{1'b0, 64'h0, 1'b0}},
      '{'{OP_ADD, 1'b0, 64'h5555_5555_5555_5555, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0,
        '{1'b0, 64'h0, 1'b0}},
      '{'{OP_ADD, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b1, 64'hFEDC_BA98_7654_3210}, 1'b0,
        '{1'b0, 64'h0, 1'b0}},
      // long borrow and carry chains and top-digit compare
      '{'{OP_SUB, 1'b0, 64'h1000_0000_0000_0000, 1'b0, 64'h1}, 1'b0, '{1'b0, 64'h0, 1'b0}},
      '{'{OP_SUB, 1'b0, 64'h0999_9999_9999_9999, 1'b0, 64'h1000_0000_0000_0000}, 1'b0,
        '{1'b0, 64'h0, 1'b0}},
      '{'{OP_ADD, 1'b0, 64'h0000_0000_0000_0001, 1'b0, 64'h0999_9999_9999_9999}, 1'b0,
        '{1'b0, 64'h0, 1'b0}}
    };

    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_ADD;
    req_ch.a_neg   = 1'b0;
    req_ch.a_bcd   = '0;
    req_ch.b_neg   = 1'b0;
    req_ch.b_bcd   = '0;
    res_ch.ready   = 1'b0;
    n_sent         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].r, dir_rows[i].typed ? dir_rows[i].want : predict_sum(dir_rows[i].r));
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      for (int k = 0; k < RAND_PER_PH; k++) begin
        r = rand_req();
        send_req(r, predict_sum(r));
      end
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("requests sent %0d, results checked %0d (%0d overflow, %0d negative)",
             n_sent, n_checked, n_ovf, n_neg);
    $display("phases: back to back, sender idle, receiver stall, both idle and stall");
    if (sum_errors == 0 && pending_sums.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bsas_pkg.sv
rtl/bsas_if.sv
rtl/bsas_mag_unit.sv
rtl/bcd_sign_magnitude_add_sub.sv
sim/bcd_sign_magnitude_add_sub_tb.sv
